@@ src/sbfa_pkg.sv @@
// sbfa_pkg: types, constants and helpers for the segregated best-fit allocator
// no dependencies
package sbfa_pkg;

    localparam int FreeEntries = 32;
    localparam int FreeIdxW    = $clog2(FreeEntries);
    localparam int FreeCntW    = $clog2(FreeEntries + 1);
    localparam int StoreDepth  = 4096;
    localparam int StoreIdxW   = 12;
    localparam int ClassCount  = 7;
    localparam logic [16:0] HeaderBytes = 17'd16;
    localparam logic [16:0] RegionBytes = 17'd65536;
    localparam logic [16:0] LimitReset  = 17'd65536;

    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StOom  = 2'd1;
    localparam logic [1:0] StNull = 2'd2;
    localparam logic [1:0] StFull = 2'd3;

    localparam logic OpAlloc = 1'b0;

    typedef struct packed {
        logic        opcode;
        logic [16:0] request_size;
        logic [15:0] free_address;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] user_address;
        logic [16:0] granted_size;
        logic        from_free_list;
    } t_out_beat;

    typedef struct packed {
        logic [2:0]  cls;
        logic [15:0] start;
        logic [16:0] bytes;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_ALIGN, S_SCAN, S_PICK, S_SHIFT, S_SPLIT,
        S_BUMP, S_FREE_RD, S_FREE_WT, S_FREE_PUSH, S_OUT
    } t_state;

    // table control from sequencer to free table: shift, push and scan read index
    typedef struct packed {
        logic        shift;
        logic        push;
        t_entry      push_entry;
        logic [FreeIdxW-1:0] rd_idx;
    } t_tbl_ctl;

    function automatic logic [2:0] class_of(input logic [16:0] bytes);
        logic [2:0] k;
        k = 3'(ClassCount - 1);
        for (int i = ClassCount - 2; i >= 0; i--) begin
            if (bytes <= (17'd8 << i)) k = 3'(i);
        end
        return k;
    endfunction

endpackage

@@ src/sbfa_table.sv @@
// sbfa_table: packed free-entry table, oldest first, with push and ordered removal
// depends on sbfa_pkg
module sbfa_table (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sbfa_pkg::t_tbl_ctl     i_ctl,
    input  logic [sbfa_pkg::FreeIdxW-1:0] i_rm_idx,
    output sbfa_pkg::t_entry       o_rd,
    output logic [sbfa_pkg::FreeCntW-1:0] o_count
);
    import sbfa_pkg::*;

    t_entry r_ent [FreeEntries];
    logic [FreeCntW-1:0] r_count;

    // count: one step of removal lowers it by one (entries from the removal point shift down by one), a push raises it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.shift) begin
            r_count <= r_count - FreeCntW'(1);
        end else if (i_ctl.push) begin
            r_count <= r_count + FreeCntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < FreeEntries - 1; i++) begin
                if (FreeIdxW'(i) >= i_rm_idx) r_ent[i] <= r_ent[i+1];
            end
        end else if (i_ctl.push) begin
            r_ent[r_count[FreeIdxW-1:0]] <= i_ctl.push_entry;
        end
    end

    assign o_rd    = r_ent[i_ctl.rd_idx];
    assign o_count = r_count;
endmodule

@@ src/segregated_best_fit_allocator_top.sv @@
// segregated_best_fit_allocator_top: sequencer, compare unit, size store, apb register
// depends on sbfa_pkg and sbfa_table
//
// channel  dir  signals                   payload
// in       in   i_in_valid / o_in_ready   t_in_beat
// out      out  o_out_valid / i_out_ready t_out_beat
// apb      in   psel penable pwrite ...   heap_limit at address 0
//
// allocate: align, a scan step for each table entry, then pick and split on a reuse or bump on a miss
// (one comparator walks every valid entry newest first)
// free: align, size store read (registered), wait, then push; a null free goes straight
// to the result; after the result the sequencer returns to idle, where the next beat is taken
// the result sits in an output register and holds the input off until it is accepted
// reset clears the table count and bump pointer and sets heap_limit to 65536; size store is not cleared
module segregated_best_fit_allocator_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sbfa_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sbfa_pkg::t_out_beat  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import sbfa_pkg::*;

    t_state r_state, n_state;
    logic [16:0] r_limit, r_bump, n_bump;
    t_in_beat r_in;
    logic [16:0] r_aligned, n_aligned;
    logic [2:0]  r_cls, n_cls;
    logic [FreeCntW-1:0] r_i, n_i;
    logic        r_found, n_found;
    logic [FreeIdxW-1:0] r_best, n_best;
    t_entry      r_bent, n_bent;
    logic [FreeCntW-1:0] r_shl, n_shl;
    t_out_beat   r_out, n_out;
    t_tbl_ctl    s_ctl;
    t_entry      s_rd;
    logic [FreeCntW-1:0] s_count;
    logic [16:0] r_sz;
    logic [15:0] s_fstart;
    logic        s_st_we;
    logic [StoreIdxW-1:0] s_st_addr;
    logic [16:0] s_st_wd;
    logic [16:0] r_store [StoreDepth];

    sbfa_table u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(s_ctl), .i_rm_idx(r_best),
        .o_rd(s_rd), .o_count(s_count)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {15'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_limit <= pwdata[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_st_we) r_store[s_st_addr] <= s_st_wd;
        r_sz <= r_store[s_st_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bump  <= '0;
        end else begin
            r_state <= n_state;
            r_bump  <= n_bump;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) r_in <= i_in_data;
        r_aligned <= n_aligned;
        r_cls     <= n_cls;
        r_i       <= n_i;
        r_found   <= n_found;
        r_best    <= n_best;
        r_bent    <= n_bent;
        r_shl     <= n_shl;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;
    assign s_fstart    = r_in.free_address - 16'(HeaderBytes);

    always_comb begin
        logic [17:0] v_end;
        logic [16:0] v_lim;
        logic [17:0] v_al;
        n_state = r_state;
        n_bump = r_bump;
        n_aligned = r_aligned;
        n_cls = r_cls;
        n_i = r_i;
        n_found = r_found;
        n_best = r_best;
        n_bent = r_bent;
        n_shl = r_shl;
        n_out = r_out;
        s_ctl = '0;
        s_st_we = 1'b0;
        s_st_addr = s_fstart[15:4];
        s_st_wd = r_bent.bytes;
        v_end = 18'(r_bump) + 18'(r_aligned);
        v_lim = (r_limit < RegionBytes) ? r_limit : RegionBytes;
        v_al = 18'(r_in.request_size) + 18'd31;
        s_ctl.rd_idx = FreeIdxW'(r_i - FreeCntW'(1));
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_ALIGN;
            end
            S_ALIGN: begin
                n_out = '0;
                if (r_in.opcode == OpAlloc) begin
                    n_aligned = {v_al[16:4], 4'd0};
                    n_cls = (v_al[17]) ? 3'(ClassCount - 1)
                                       : class_of({v_al[16:4], 4'd0});
                    if (v_al[17]) n_aligned = 17'h1fff0;
                    n_i = s_count;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end else if (r_in.free_address == '0) begin
                    n_out.status = StNull;
                    n_state = S_OUT;
                end else begin
                    n_state = S_FREE_RD;
                end
            end
            S_SCAN: begin
                if (r_i == '0) begin
                    n_state = r_found ? S_PICK : S_BUMP;
                end else begin
                    if (s_rd.cls == r_cls && s_rd.bytes >= r_aligned &&
                        (!r_found || s_rd.bytes < r_bent.bytes)) begin
                        n_found = 1'b1;
                        n_best = FreeIdxW'(r_i - FreeCntW'(1));
                        n_bent = s_rd;
                    end
                    n_i = r_i - FreeCntW'(1);
                end
            end
            S_PICK: begin
                s_ctl.shift = 1'b1;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                n_out.from_free_list = 1'b1;
                n_out.user_address = r_bent.start + 16'(HeaderBytes);
                s_st_addr = r_bent.start[15:4];
                s_st_we = 1'b1;
                if (18'(r_bent.bytes) >= 18'(r_aligned) + 18'(HeaderBytes)) begin
                    s_ctl.push = 1'b1;
                    s_ctl.push_entry.cls = r_cls;
                    s_ctl.push_entry.start = r_bent.start + r_aligned[15:0];
                    s_ctl.push_entry.bytes = r_bent.bytes - r_aligned;
                    s_st_wd = r_aligned;
                    n_out.granted_size = r_aligned;
                end else begin
                    n_out.granted_size = r_bent.bytes;
                end
                n_state = S_OUT;
            end
            S_BUMP: begin
                if (v_end > 18'(v_lim) || 18'(r_bump) + 18'(HeaderBytes) > 18'hffff
                    || r_in.request_size > 17'h1ffe0) begin
                    n_out.status = StOom;
                end else begin
                    n_bump = v_end[16:0];
                    s_st_addr = r_bump[15:4];
                    s_st_we = 1'b1;
                    s_st_wd = r_aligned;
                    n_out.user_address = r_bump[15:0] + 16'(HeaderBytes);
                    n_out.granted_size = r_aligned;
                end
                n_state = S_OUT;
            end
            S_FREE_RD: n_state = S_FREE_WT;
            S_FREE_WT: n_state = S_FREE_PUSH;
            S_FREE_PUSH: begin
                if (s_count >= FreeCntW'(FreeEntries)) begin
                    n_out.status = StFull;
                end else begin
                    s_ctl.push = 1'b1;
                    s_ctl.push_entry.cls = class_of(r_sz);
                    s_ctl.push_entry.start = s_fstart;
                    s_ctl.push_entry.bytes = r_sz;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_count <= FreeCntW'(FreeEntries)) else $error("table count overflow");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != StOk |-> o_out_data.granted_size == '0)
        else $error("failed result carries a size");
    a_bump_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |=> r_bump == $past(r_bump)) else $error("bump moved idle");
endmodule

@@ tb/segregated_best_fit_allocator_top_tb.sv @@
// segregated_best_fit_allocator_top_tb: self-checking testbench for the allocator top
// queue-fed driver, monitor against a free-table/bump-pointer predictor, apb heap_limit writes
// depends on sbfa_pkg and segregated_best_fit_allocator_top
module segregated_best_fit_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbfa_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int HoldCycles    = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    t_in_beat    in_data = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_out_beat   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    segregated_best_fit_allocator_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    t_in_beat    pending_beats[$];
    t_out_beat   expected_results[$];
    t_entry      spare_blocks[$];
    logic [16:0] bump_ptr = '0;
    logic [16:0] limit_shadow = LimitReset;
    logic [16:0] size_store[StoreDepth];
    bit          size_written[StoreDepth];
    logic [15:0] written_starts[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_left = 0;
    bit  in_taken = 1'b0;
    int  errors = 0;
    int  quiet_cycles = 0;
    int  n_alloc = 0, n_free = 0, n_reuse = 0, n_oom = 0, n_full = 0, n_null = 0;

    function automatic logic [2:0] size_class(input logic [16:0] bytes);
        int unsigned bs;
        int k;
        bs = 8;
        k = 0;
        while (bs < bytes && k < ClassCount - 1) begin
            bs = bs << 1;
            k++;
        end
        return 3'(k);
    endfunction

    task automatic note_size(input logic [15:0] start, input logic [16:0] bytes);
        logic [StoreIdxW-1:0] idx;
        idx = start[15:4];
        size_store[idx] = bytes;
        if (!size_written[idx]) begin
            size_written[idx] = 1'b1;
            written_starts.push_back(start);
        end
    endtask

    task automatic predict_grant(input t_in_beat b);
        t_out_beat   r;
        t_entry      e;
        int unsigned aligned;
        logic [2:0]  cls;
        int          best;
        logic [15:0] start;
        int unsigned bytes;
        r = '0;
        best = -1;
        if (b.opcode == OpAlloc) begin
            n_alloc++;
            aligned = (int'(b.request_size) + 31) & ~32'd15;
            cls = size_class(17'(aligned > 17'h1ffff ? 17'h1ffff : aligned));
            if (aligned > 65536) cls = 3'(ClassCount - 1);
            for (int i = spare_blocks.size() - 1; i >= 0; i--) begin
                if (spare_blocks[i].cls == cls && spare_blocks[i].bytes >= aligned &&
                    (best < 0 || spare_blocks[i].bytes < spare_blocks[best].bytes))
                    best = i;
            end
            if (best >= 0) begin
                start = spare_blocks[best].start;
                bytes = spare_blocks[best].bytes;
                spare_blocks.delete(best);
                if (bytes >= aligned + 16) begin
                    e.cls = cls;
                    e.start = 16'(start + aligned);
                    e.bytes = 17'(bytes - aligned);
                    spare_blocks.push_back(e);
                    bytes = aligned;
                end
                note_size(start, 17'(bytes));
                r.user_address = 16'(start + 16);
                r.granted_size = 17'(bytes);
                r.from_free_list = 1'b1;
                n_reuse++;
            end else if (int'(bump_ptr) + aligned >
                         (limit_shadow < RegionBytes ? int'(limit_shadow) : 65536) ||
                         int'(bump_ptr) + 16 > 65535) begin
                r.status = StOom;
                n_oom++;
            end else begin
                start = 16'(bump_ptr);
                bump_ptr = 17'(bump_ptr + aligned);
                note_size(start, 17'(aligned));
                r.user_address = 16'(start + 16);
                r.granted_size = 17'(aligned);
            end
        end else begin
            n_free++;
            if (b.free_address == 16'd0) begin
                r.status = StNull;
                n_null++;
            end else begin
                start = 16'(b.free_address - 16);
                if (spare_blocks.size() >= FreeEntries) begin
                    r.status = StFull;
                    n_full++;
                end else begin
                    e.bytes = size_store[start[15:4]];
                    e.cls = size_class(e.bytes);
                    e.start = start;
                    spare_blocks.push_back(e);
                end
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        in_taken <= in_valid && o_in_ready;
        if (i_rst_n && in_valid && o_in_ready) predict_grant(in_data);
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %p", $time, o_out_data);
            end else if (o_out_data !== expected_results[0]) begin
                errors++;
                $display("%0t: mismatch expected %p actual %p", $time,
                         expected_results[0], o_out_data);
                void'(expected_results.pop_front());
            end else begin
                void'(expected_results.pop_front());
            end
        end
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("segregated_best_fit_allocator_top regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!in_valid || in_taken) begin
            if (i_rst_n && pending_beats.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                in_data <= pending_beats.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [16:0] value);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_shadow = value;
    endtask

    task automatic queue_beat(input t_in_beat b);
        while (pending_beats.size() > 1) @(negedge i_clk);
        pending_beats.push_back(b);
    endtask

    task automatic queue_alloc(input logic [16:0] req);
        t_in_beat b;
        b.opcode = OpAlloc;
        b.request_size = req;
        b.free_address = 16'($urandom);
        queue_beat(b);
    endtask

    task automatic queue_free(input bit null_free);
        t_in_beat b;
        b.opcode = ~OpAlloc;
        b.request_size = 17'($urandom);
        if (null_free || written_starts.size() == 0) b.free_address = 16'd0;
        else b.free_address = 16'(written_starts[$urandom_range(written_starts.size() - 1)]
                                   + 16 + $urandom_range(15));
        queue_beat(b);
    endtask

    task automatic random_items(input int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 55) begin
                sel = $urandom_range(99);
                if (sel < 70) queue_alloc(17'($urandom_range(240)));
                else if (sel < 90) queue_alloc(17'($urandom_range(4000)));
                else if (sel < 95) queue_alloc(17'($urandom_range(65536)));
                else queue_alloc(17'($urandom));
            end else begin
                queue_free($urandom_range(99) < 5);
            end
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: extremes, splits, reuse, null and double frees
        queue_alloc(17'd0);
        queue_alloc(17'd1);
        queue_alloc(17'd112);
        queue_alloc(17'd1000);
        queue_alloc(17'd65536);
        queue_alloc(17'h1ffff);
        queue_alloc(17'd30000);
        wait_drained();
        for (int i = 0; i < written_starts.size(); i++) begin
            queue_beat('{opcode: ~OpAlloc, request_size: 17'h1ffff,
                         free_address: 16'(written_starts[i] + 16)});
        end
        queue_free(1'b1);
        queue_beat('{opcode: ~OpAlloc, request_size: '0,
                     free_address: 16'(written_starts[2] + 16)});
        queue_alloc(17'd100);
        queue_alloc(17'd500);
        queue_alloc(17'd16);
        queue_alloc(17'd990);
        queue_alloc(17'd100000);
        write_limit(17'd16);
        queue_alloc(17'd0);
        queue_alloc(17'd4000);
        for (int i = 0; i < 34; i++) queue_free(1'b0);
        queue_alloc(17'd0);
        random_items(180);
        write_limit(17'd65536);
        random_items(220);
        send_idle_pct = 81;
        write_limit(17'd40000);
        random_items(220);
        send_idle_pct = 0;
        recv_stall_pct = 81;
        write_limit(17'd65535);
        hold_left = HoldCycles;
        random_items(220);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        write_limit(17'd65536);
        random_items(220);
        wait_drained();
        $display("covered %0d allocates (%0d reused, %0d out of memory), %0d frees",
                 n_alloc, n_reuse, n_oom, n_free);
        $display("with %0d null and %0d table-full frees over five heap limits",
                 n_null, n_full);
        if (errors == 0) begin
            $display("segregated_best_fit_allocator_top regression: pass");
        end else begin
            $display("segregated_best_fit_allocator_top regression: fail");
        end
        $finish;
    end
endmodule
